>>> rtl/core/mpq_pkg.sv
package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int OCC_W    = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_key;
    logic                    removed_valid;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } out_item_t;

  // Broadcast to every cell of the chain for one beat.
  typedef struct packed {
    logic                    insert;
    logic                    delete_min;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

>>> rtl/core/min_priority_queue_top.sv
// Bounded min priority queue built as a sorted chain of CAPACITY cells, smallest
// key in the first cell. Each input beat is an insert of a signed key or a
// delete-min, and each yields exactly one result beat carrying the removed key
// (delete only), a status (ok, delete on empty, insert dropped because full) and
// the occupancy after the item. On insert every cell compares its key with the
// broadcast new key in the same cycle and the tail of the chain shifts right by
// one; on delete the whole chain shifts left by one. So one beat can enter every
// cycle while the output register is not held by a stalled sink: the rate is
// set by the single 32-bit compare in each cell plus the neighbor select. A
// result sits in an output register; the next input beat is taken while that
// register is free or being drained in the same cycle. Duplicate keys are kept.
// No clearing pass is needed after reset.
module min_priority_queue_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mpq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mpq_pkg::out_item_t out_item_o
);
  import mpq_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic                    cell_valid [CAPACITY];
  logic                    cell_moves [CAPACITY];

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_item_t        out_item_q, out_item_d;
  cell_ctrl_t       ctrl;
  logic             accept;
  logic             full, empty;

  // Hold input while a result waits and the sink stalls.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CAP_CNT);
  assign empty = (count_q == '0);

  // Drive the chain only for items that change the state.
  always_comb begin
    ctrl.key        = in_item_i.key;
    ctrl.insert     = accept && (in_item_i.command == CMD_INSERT) && !full;
    ctrl.delete_min = accept && (in_item_i.command == CMD_DELETE) && !empty;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_key, right_key;
    logic                    left_valid, left_moves, right_valid;

    if (i == 0) begin : g_head
      assign left_key   = '0;
      assign left_valid = 1'b0;
      assign left_moves = 1'b0;
    end else begin : g_body
      assign left_key   = cell_key[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_moves = cell_moves[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_key   = cell_key[i+1];
      assign right_valid = cell_valid[i+1];
    end

    mpq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_key_i    (left_key),
      .left_valid_i  (left_valid),
      .left_moves_i  (left_moves),
      .right_key_i   (right_key),
      .right_valid_i (right_valid),
      .key_o         (cell_key[i]),
      .valid_o       (cell_valid[i]),
      .moves_o       (cell_moves[i])
    );
  end

  // Build the result beat from the head cell and the updated count.
  always_comb begin
    count_d                  = count_q;
    out_item_d.removed_key   = '0;
    out_item_d.removed_valid = 1'b0;
    out_item_d.status        = STATUS_OK;
    if (in_item_i.command == CMD_INSERT) begin
      if (full) begin
        out_item_d.status = STATUS_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        out_item_d.status = STATUS_EMPTY;
      end else begin
        count_d                  = count_q - 1'b1;
        out_item_d.removed_key   = cell_key[0];
        out_item_d.removed_valid = 1'b1;
      end
    end
    out_item_d.occupancy = OCC_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Advance the result register on every accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/core/mpq_cell.sv
module mpq_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mpq_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [mpq_pkg::KEY_W-1:0] left_key_i,
  input  logic                            left_valid_i,
  input  logic                            left_moves_i,
  input  logic signed [mpq_pkg::KEY_W-1:0] right_key_i,
  input  logic                            right_valid_i,
  output logic signed [mpq_pkg::KEY_W-1:0] key_o,
  output logic                            valid_o,
  output logic                            moves_o
);
  import mpq_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    valid_q, valid_d;

  // Cell content moves right on insert when it is empty or larger than the new key.
  assign moves_o = !valid_q || (key_q > ctrl_i.key);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.insert && moves_o) begin
      if (!left_moves_i) begin
        key_d   = ctrl_i.key;
        valid_d = 1'b1;
      end else begin
        key_d   = left_key_i;
        valid_d = left_valid_i;
      end
    end else if (ctrl_i.delete_min) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule
